@@ sv/nrts_pkg.sv @@
// ----------------------------------------------------------------------------
// nrts_pkg
// Types and constants shared by the nearest radar target select block.
// ----------------------------------------------------------------------------
package nrts_pkg;

  localparam int unsigned MaxTargets = 20;
  localparam int unsigned CountW     = $clog2(MaxTargets + 1);

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] MaxDistanceRst      = 16'd500;
  localparam logic [6:0]  SideAngleLimitRst   = 7'd45;
  localparam logic [6:0]  CenterAngleLimitRst = 7'd10;
  localparam logic [7:0]  SpeedCeilingRst     = 8'd250;
  localparam logic [15:0] BestDistanceRst     = 16'hFFFF;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxDistance      = 8'd0,
    CfgSideAngleLimit   = 8'd1,
    CfgCenterAngleLimit = 8'd2,
    CfgSpeedCeiling     = 8'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DirNone   = 2'd0,
    DirCenter = 2'd1,
    DirLeft   = 2'd2,
    DirRight  = 2'd3
  } dir_e;

  typedef struct packed {
    logic [15:0] max_distance;
    logic [6:0]  side_angle_limit;
    logic [6:0]  center_angle_limit;
    logic [7:0]  speed_ceiling;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [15:0]        distance;
    logic signed [7:0]  angle;
    logic signed [15:0] speed;
    logic [4:0]         position;
  } best_t;

  localparam best_t BestRst = '{
    valid:    1'b0,
    distance: BestDistanceRst,
    angle:    8'sd0,
    speed:    16'sd0,
    position: 5'd0
  };

endpackage

@@ sv/nrts_if.sv @@
// ----------------------------------------------------------------------------
// nrts interfaces
// Target input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface nrts_in_if;
  logic               valid;
  logic               ready;
  logic               present;
  logic signed [7:0]  angle;
  logic [15:0]        distance;
  logic signed [15:0] speed;
  logic               last;

  modport source (output valid, present, angle, distance, speed, last, input ready);
  modport sink   (input valid, present, angle, distance, speed, last, output ready);
endinterface

interface nrts_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [4:0] chosen_index;
  logic [1:0] direction;
  logic [7:0] speed_magnitude;

  modport source (output valid, found, chosen_index, direction, speed_magnitude,
                  input ready);
  modport sink   (input valid, found, chosen_index, direction, speed_magnitude,
                  output ready);
endinterface

interface nrts_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [nrts_pkg::CfgIdxW-1:0]  index;
  logic [nrts_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/nrts_cfg.sv @@
// ----------------------------------------------------------------------------
// nrts_cfg
// Configuration register file for the target selector.
// ----------------------------------------------------------------------------
module nrts_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_i,
  input  logic [nrts_pkg::CfgIdxW-1:0]  index_i,
  input  logic [nrts_pkg::CfgDataW-1:0] data_i,
  output nrts_pkg::cfg_t                cfg_o
);

  nrts_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      unique case (index_i)
        nrts_pkg::CfgMaxDistance:      cfg_d.max_distance       = data_i[15:0];
        nrts_pkg::CfgSideAngleLimit:   cfg_d.side_angle_limit   = data_i[6:0];
        nrts_pkg::CfgCenterAngleLimit: cfg_d.center_angle_limit = data_i[6:0];
        nrts_pkg::CfgSpeedCeiling:     cfg_d.speed_ceiling      = data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_distance       <= nrts_pkg::MaxDistanceRst;
      cfg_q.side_angle_limit   <= nrts_pkg::SideAngleLimitRst;
      cfg_q.center_angle_limit <= nrts_pkg::CenterAngleLimitRst;
      cfg_q.speed_ceiling      <= nrts_pkg::SpeedCeilingRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/nrts_track.sv @@
// ----------------------------------------------------------------------------
// nrts_track
// Running nearest target of the current frame and the frame position count.
// ----------------------------------------------------------------------------
module nrts_track (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               present_i,
  input  logic signed [7:0]  angle_i,
  input  logic [15:0]        distance_i,
  input  logic signed [15:0] speed_i,
  input  logic               last_i,
  input  nrts_pkg::cfg_t     cfg_i,
  output nrts_pkg::best_t    best_o
);

  logic [nrts_pkg::CountW-1:0] count_q, count_d;
  nrts_pkg::best_t             best_q, best_d;
  logic                        in_window;
  logic [7:0]                  abs_angle;
  logic                        take;

  assign in_window = present_i && (count_q < nrts_pkg::CountW'(nrts_pkg::MaxTargets));
  assign abs_angle = angle_i[7] ? 8'(-angle_i) : 8'(angle_i);
  assign take = in_window && (distance_i != 16'd0) &&
                (distance_i <= cfg_i.max_distance) &&
                (abs_angle <= {1'b0, cfg_i.side_angle_limit}) &&
                (!best_q.valid || (distance_i < best_q.distance));

  // best including the current word, also used for the report
  always_comb begin
    best_d  = best_q;
    count_d = count_q;
    if (take) begin
      best_d.valid    = 1'b1;
      best_d.distance = distance_i;
      best_d.angle    = angle_i;
      best_d.speed    = speed_i;
      best_d.position = 5'(count_q);
    end
    if (in_window) begin
      count_d = count_q + nrts_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      best_q   <= nrts_pkg::BestRst;
    end else if (accept_i) begin
      if (last_i) begin
        count_q  <= '0;
        best_q   <= nrts_pkg::BestRst;
      end else begin
        count_q <= count_d;
        best_q  <= best_d;
      end
    end
  end

  assign best_o = best_d;

endmodule

@@ sv/nrts_report.sv @@
// ----------------------------------------------------------------------------
// nrts_report
// Builds the frame result from the chosen target and holds it in the output
// register until it is taken.
// ----------------------------------------------------------------------------
module nrts_report (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  nrts_pkg::best_t best_i,
  input  nrts_pkg::cfg_t  cfg_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic            found_o,
  output logic [4:0]      chosen_index_o,
  output logic [1:0]      direction_o,
  output logic [7:0]      speed_magnitude_o,
  output logic            full_o
);

  logic        valid_q, valid_d;
  logic        found_q;
  logic [4:0]  index_q, index_d;
  logic [1:0]  dir_q;
  logic [7:0]  mag_q, mag_d;
  nrts_pkg::dir_e dir_d;
  logic [7:0]  abs_angle;
  logic [15:0] abs_speed;

  assign abs_angle = best_i.angle[7] ? 8'(-best_i.angle) : 8'(best_i.angle);
  assign abs_speed = best_i.speed[15] ? 16'(-best_i.speed) : 16'(best_i.speed);

  always_comb begin
    index_d = '0;
    dir_d   = nrts_pkg::DirNone;
    mag_d   = '0;
    if (best_i.valid) begin
      index_d = best_i.position;
      if (abs_angle <= {1'b0, cfg_i.center_angle_limit}) begin
        dir_d = nrts_pkg::DirCenter;
      end else if (best_i.angle[7]) begin
        dir_d = nrts_pkg::DirLeft;
      end else begin
        dir_d = nrts_pkg::DirRight;
      end
      mag_d = (abs_speed > {8'd0, cfg_i.speed_ceiling}) ? cfg_i.speed_ceiling
                                                         : abs_speed[7:0];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      found_q <= best_i.valid;
      index_q <= index_d;
      dir_q   <= dir_d;
      mag_q   <= mag_d;
    end
  end

  assign out_valid_o       = valid_q;
  assign found_o           = found_q;
  assign chosen_index_o    = index_q;
  assign direction_o       = dir_q;
  assign speed_magnitude_o = mag_q;
  assign full_o            = valid_q && !out_ready_i;

endmodule

@@ sv/nearest_radar_target_select_core.sv @@
// ----------------------------------------------------------------------------
// nearest_radar_target_select_core
// Picks the nearest accepted radar target of each frame and reports it.
// ----------------------------------------------------------------------------
// One target word is taken every clock cycle while input ready is high. The
// running nearest target is updated by a single compare stage in the same
// cycle, and the result of a frame is loaded into the output register in the
// cycle after its last word is accepted. Input ready drops only while that
// register holds a result that is not taken; no clearing pass follows reset.
module nearest_radar_target_select_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  nrts_in_if.sink          in_i,
  nrts_out_if.source       out_o,
  nrts_cfg_if.sink         cfg_i
);

  nrts_pkg::cfg_t  cfg;
  nrts_pkg::best_t best;
  logic            in_accept;
  logic            out_full;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_full;
  assign in_accept   = in_i.valid && in_i.ready;

  nrts_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_i.valid),
    .index_i (cfg_i.index),
    .data_i  (cfg_i.data),
    .cfg_o   (cfg)
  );

  nrts_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .present_i  (in_i.present),
    .angle_i    (in_i.angle),
    .distance_i (in_i.distance),
    .speed_i    (in_i.speed),
    .last_i     (in_i.last),
    .cfg_i      (cfg),
    .best_o     (best)
  );

  nrts_report u_report (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (in_accept && in_i.last),
    .best_i            (best),
    .cfg_i             (cfg),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .found_o           (out_o.found),
    .chosen_index_o    (out_o.chosen_index),
    .direction_o       (out_o.direction),
    .speed_magnitude_o (out_o.speed_magnitude),
    .full_o            (out_full)
  );

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives target frames into nearest_radar_target_select_core and checks each
// frame report against a running nearest-target predictor kept in step with
// every accepted word and register write. Directed frames cover the accept
// bounds, ties, the target limit and the limit extremes. Random frames
// follow under several limit settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import nrts_pkg::*;

  typedef struct packed {
    logic               present;
    logic signed [7:0]  angle;
    logic [15:0]        distance;
    logic signed [15:0] speed;
    logic               last;
  } target_t;

  typedef struct packed {
    logic       found;
    logic [4:0] chosen_index;
    dir_e       direction;
    logic [7:0] speed_magnitude;
  } report_t;

  logic clk_i;
  logic rst_ni;

  nrts_in_if  in_if ();
  nrts_out_if out_if ();
  nrts_cfg_if cfg_if ();

  nearest_radar_target_select_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  cfg_t        lim;
  best_t       nearest;
  int unsigned frame_count;
  report_t     expected_reports[$];
  int          error_count;
  int          send_gap_pct;
  int          sink_stall_pct;
  report_t     want;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(4 * 600000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= (int'($urandom_range(99)) >= sink_stall_pct);
    end
  end

  function automatic int unsigned abs_of(input int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic clear_frame();
    frame_count = 0;
    nearest = '0;
    nearest.distance = BestDistanceRst;
  endtask

  task automatic track_nearest(input target_t t);
    int unsigned mag;
    report_t r;
    if (t.present && frame_count < MaxTargets) begin
      mag = abs_of(int'(t.angle));
      if (t.distance != 0 && t.distance <= lim.max_distance &&
          mag <= lim.side_angle_limit &&
          (!nearest.valid || t.distance < nearest.distance)) begin
        nearest.valid    = 1'b1;
        nearest.distance = t.distance;
        nearest.angle    = t.angle;
        nearest.speed    = t.speed;
        nearest.position = 5'(frame_count);
      end
      frame_count++;
    end
    if (t.last) begin
      r = '0;
      r.direction = DirNone;
      if (nearest.valid) begin
        r.found        = 1'b1;
        r.chosen_index = nearest.position;
        if (abs_of(int'(nearest.angle)) <= lim.center_angle_limit) r.direction = DirCenter;
        else if (nearest.angle < 0) r.direction = DirLeft;
        else r.direction = DirRight;
        mag = abs_of(int'(nearest.speed));
        if (mag > lim.speed_ceiling) mag = lim.speed_ceiling;
        r.speed_magnitude = 8'(mag);
      end
      expected_reports.push_back(r);
      clear_frame();
    end
  endtask

  task automatic apply_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    case (cfg_reg_e'(idx))
      CfgMaxDistance:      lim.max_distance       = data;
      CfgSideAngleLimit:   lim.side_angle_limit   = data[6:0];
      CfgCenterAngleLimit: lim.center_angle_limit = data[6:0];
      CfgSpeedCeiling:     lim.speed_ceiling      = data[7:0];
      default: ;
    endcase
  endtask

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_reports.size() == 0) begin
        note_error($sformatf("unexpected report word: found %0b index %0d dir %0d speed %0d",
                             out_if.found, out_if.chosen_index, out_if.direction,
                             out_if.speed_magnitude));
      end else begin
        want = expected_reports.pop_front();
        if (out_if.found !== want.found || out_if.chosen_index !== want.chosen_index ||
            out_if.direction !== want.direction ||
            out_if.speed_magnitude !== want.speed_magnitude) begin
          note_error($sformatf({"report mismatch: expected found %0b index %0d dir %s ",
                                "speed %0d, got found %0b index %0d dir %0d speed %0d"},
                               want.found, want.chosen_index, want.direction.name(),
                               want.speed_magnitude, out_if.found, out_if.chosen_index,
                               out_if.direction, out_if.speed_magnitude));
        end
      end
    end
  end

  // called just after a falling edge, returns just after a falling edge
  task automatic send_target(input logic pres, input int ang, input int dst, input int spd,
                             input logic lst);
    target_t t;
    t.present  = pres;
    t.angle    = 8'(ang);
    t.distance = 16'(dst);
    t.speed    = 16'(spd);
    t.last     = lst;
    while (int'($urandom_range(99)) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.present  <= t.present;
    in_if.angle    <= t.angle;
    in_if.distance <= t.distance;
    in_if.speed    <= t.speed;
    in_if.last     <= t.last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    track_nearest(t);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    apply_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic set_limits(input logic [15:0] md, input logic [6:0] side,
                            input logic [6:0] ctr, input logic [7:0] ceil);
    wait_idle();
    write_reg(CfgMaxDistance, md);
    write_reg(CfgSideAngleLimit, {9'($urandom), side});
    write_reg(CfgCenterAngleLimit, {9'($urandom), ctr});
    write_reg(CfgSpeedCeiling, {8'($urandom), ceil});
    // unknown index, must leave every limit untouched
    write_reg(CfgIdxW'($urandom_range(255, int'(CfgSpeedCeiling) + 1)), 16'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_empty_frame();
    send_target(1'b0, 0, 0, 0, 1'b1);
  endtask

  task automatic test_accept_bounds();
    send_target(1'b1, 0, 0, 5, 1'b0);
    send_target(1'b1, 3, 501, 5, 1'b0);
    send_target(1'b1, 46, 10, 5, 1'b0);
    send_target(1'b1, -46, 10, 5, 1'b0);
    send_target(1'b1, -45, 500, -32768, 1'b1);
  endtask

  task automatic test_ties_and_center();
    send_target(1'b1, 10, 100, 300, 1'b0);
    send_target(1'b1, -10, 100, 7, 1'b0);
    send_target(1'b0, 0, 1, 0, 1'b0);
    send_target(1'b1, 0, 100, 1, 1'b1);
  endtask

  task automatic test_target_limit();
    send_target(1'b1, 0, 400, 20, 1'b0);
    for (int k = 1; k < 19; k++) send_target(1'b1, 0, 0, k, 1'b0);
    send_target(1'b1, -20, 399, -40, 1'b0);
    send_target(1'b1, 0, 1, 60, 1'b1);
  endtask

  task automatic test_extreme_limits();
    set_limits(16'hFFFF, 7'd127, 7'd0, 8'd255);
    send_target(1'b1, -128, 65535, 100, 1'b0);
    send_target(1'b1, 127, 65535, 32767, 1'b1);
    set_limits(16'd1, 7'd0, 7'd127, 8'd0);
    send_target(1'b1, 0, 1, -1, 1'b1);
  endtask

  task automatic send_frames(input int unsigned item_goal);
    int unsigned sent;
    int unsigned frame_len;
    int          side;
    int          ang;
    int          rnd_distance;
    int          spd;
    int          prev_dist;
    sent = 0;
    prev_dist = 1;
    while (sent < item_goal) begin
      frame_len = ($urandom_range(9) == 0) ? $urandom_range(26, 18) : $urandom_range(8, 1);
      for (int unsigned k = 0; k < frame_len; k++) begin
        side = int'(lim.side_angle_limit);
        if ($urandom_range(3) == 0) ang = int'($urandom_range(255)) - 128;
        else ang = int'($urandom_range(2 * side)) - side;
        case ($urandom_range(7))
          0: rnd_distance = int'($urandom_range(65535));
          1: rnd_distance = prev_dist;
          2: rnd_distance = int'(lim.max_distance) + int'($urandom_range(2)) - 1;
          3: rnd_distance = int'($urandom_range(3));
          default: rnd_distance = int'($urandom_range(int'(lim.max_distance)));
        endcase
        if ($urandom_range(1) == 0) spd = int'($urandom_range(65535)) - 32768;
        else spd = int'($urandom_range(600)) - 300;
        prev_dist = rnd_distance;
        send_target($urandom_range(9) != 0, ang, rnd_distance, spd, k == frame_len - 1);
      end
      sent += frame_len;
    end
  endtask

  task automatic test_random_traffic();
    for (int unsigned phase = 0; phase < 8; phase++) begin
      if (phase == 0) set_limits(16'hFFFF, 7'd127, 7'd0, 8'd255);
      else if (phase == 1) set_limits(16'd1, 7'd0, 7'd127, 8'd0);
      else if (phase == 2) set_limits(MaxDistanceRst, SideAngleLimitRst,
                                      CenterAngleLimitRst, SpeedCeilingRst);
      else set_limits(16'($urandom_range(1) ? $urandom_range(2000, 1) : $urandom_range(65535, 1)),
                      7'($urandom), 7'($urandom), 8'($urandom));
      case (phase % 4)
        0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_gap_pct = 80; sink_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  sink_stall_pct = 80; end
        default: begin send_gap_pct = 36; sink_stall_pct = 36; end
      endcase
      send_frames(130);
    end
  endtask

  initial begin
    error_count    = 0;
    send_gap_pct   = 0;
    sink_stall_pct = 0;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.present   = 1'b0;
    in_if.angle     = '0;
    in_if.distance  = '0;
    in_if.speed     = '0;
    in_if.last      = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    lim.max_distance       = MaxDistanceRst;
    lim.side_angle_limit   = SideAngleLimitRst;
    lim.center_angle_limit = CenterAngleLimitRst;
    lim.speed_ceiling      = SpeedCeilingRst;
    clear_frame();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_frame();
    test_accept_bounds();
    test_ties_and_center();
    test_target_limit();
    test_extreme_limits();
    test_random_traffic();
    wait_idle();

    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
